// ===== hdl/tempo_sample_scheduler_top_macros.svh =====
// ============================================================================
// Tempo sample scheduler assertion macros
// Immediate-consequence and next-cycle property macros for the scheduler.
// ============================================================================
`ifndef TEMPO_SAMPLE_SCHEDULER_TOP_MACROS_SVH
`define TEMPO_SAMPLE_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define TSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tempo_sample_scheduler: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define TSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tempo_sample_scheduler: next-cycle check failed");

`else

`define TSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/tss_pkg.sv =====
// ============================================================================
// Tempo sample scheduler package
// Shared types, constants and command/status structures.
// ============================================================================
package tss_pkg;

    // Song time division default and sample divisor scale.
    localparam logic [15:0] TPQ_RESET       = 16'd96;
    localparam logic [13:0] TEMPO_DIV_SCALE = 14'd10000;
    localparam int          QUARTER_SHIFT   = 2;

    // Shared divider geometry.
    localparam int DIV_DIVIDEND_W = 64;
    localparam int DIV_DIVISOR_W  = 32;
    localparam int DIV_CNT_W      = 7;

    // Significant dividend widths of the four divisions, and the sample divisor width.
    localparam int TICKS_W   = 25;
    localparam int BPB_NUM_W = 10;
    localparam int BEAT_W    = 32;
    localparam int PROD_W    = 56;
    localparam int DIVC_W    = 30;

    localparam logic [DIV_CNT_W-1:0] STEPS_TICKS = DIV_CNT_W'(TICKS_W);
    localparam logic [DIV_CNT_W-1:0] STEPS_BPB   = DIV_CNT_W'(BPB_NUM_W);
    localparam logic [DIV_CNT_W-1:0] STEPS_BEAT  = DIV_CNT_W'(BEAT_W);
    localparam logic [DIV_CNT_W-1:0] STEPS_PROD  = DIV_CNT_W'(PROD_W);

    typedef enum logic [1:0] {
        OP_TICKS,
        OP_BPB,
        OP_BEAT,
        OP_PROD
    } div_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TICK_DIV,
        ST_BPB_DIV,
        ST_BEAT_DIV,
        ST_PROD_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    do_mul;
        logic    clear_pos;
        logic    div_start;
        div_op_t div_op;
        logic    capture;
        div_op_t cap_op;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic restart;
        logic den_zero;
        logic bpb_zero;
        logic div_done;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/tss_divider.sv =====
// ============================================================================
// Tempo sample scheduler divider
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// ============================================================================
module tss_divider
    import tss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIV_DIVIDEND_W-1:0] dividend,
    input  logic [DIV_DIVISOR_W-1:0]  divisor,
    input  logic [DIV_CNT_W-1:0]      steps,
    output logic                      busy,
    output logic                      done,
    output logic [DIV_DIVIDEND_W-1:0] quotient,
    output logic [DIV_DIVISOR_W-1:0]  remainder
);

    logic [DIV_DIVIDEND_W-1:0] quot_reg;
    logic [DIV_DIVISOR_W-1:0]  rem_reg;
    logic [DIV_DIVISOR_W-1:0]  divisor_reg;
    logic [DIV_CNT_W-1:0]      count_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [DIV_DIVISOR_W:0]    trial;
    logic [DIV_DIVISOR_W:0]    diff;
    logic                      fits;
    logic [DIV_DIVISOR_W-1:0]  rem_step;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quot_reg[DIV_DIVIDEND_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_step = fits ? diff[DIV_DIVISOR_W-1:0] : trial[DIV_DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= steps;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == DIV_CNT_W'(1));
            if (busy_reg)
            begin
                count_reg <= count_reg - DIV_CNT_W'(1);
                if (count_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_DIVIDEND_W-2:0], fits};
            rem_reg  <= rem_step;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/tss_datapath.sv =====
// ============================================================================
// Tempo sample scheduler datapath
// Input capture, musical position, sample conversion and result register.
// ============================================================================
module tss_datapath
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        kind,
    input  logic [23:0] elapsed_ticks,
    input  logic [23:0] next_ticks,
    input  logic [31:0] tempo_scaled,
    input  logic [7:0]  meter_num,
    input  logic [7:0]  meter_den,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_delta,
    output logic [31:0] bar_count,
    output logic [31:0] beat_count,
    output logic [15:0] tick_in_beat
);

    // Configuration and captured transaction.
    logic [15:0]         tpq_reg;
    logic                kind_reg;
    logic [23:0]         elapsed_reg;
    logic [23:0]         next_reg;
    logic [31:0]         tempo_reg;
    logic [7:0]          num_reg;
    logic [7:0]          den_reg;

    // Position state and sample remainder.
    logic [31:0]         remacc_reg;
    logic [15:0]         tick_pos_reg;
    logic [31:0]         beat_pos_reg;
    logic [31:0]         bar_pos_reg;

    logic [PROD_W-1:0]   prod_reg;
    logic [DIVC_W-1:0]   divc_reg;
    logic [31:0]         delta_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [31:0]         sample_delta_reg;
    logic [31:0]         bar_count_reg;
    logic [31:0]         beat_count_reg;
    logic [15:0]         tick_in_beat_reg;

    logic [15:0]         tpq_eff;
    logic [TICKS_W-1:0]  ticks_sum;
    logic [PROD_W-1:0]   prod_next;
    logic [DIVC_W-1:0]   divc_next;
    logic [32:0]         rem_sum;
    logic [31:0]         delta_next;

    logic [DIV_DIVIDEND_W-1:0] div_dividend;
    logic [DIV_DIVISOR_W-1:0]  div_divisor;
    logic [DIV_CNT_W-1:0]      div_steps;
    logic                      div_busy;
    logic                      div_done;
    logic [DIV_DIVIDEND_W-1:0] div_quot;
    logic [DIV_DIVISOR_W-1:0]  div_rem;

    // A zero time division behaves as one tick per quarter.
    assign tpq_eff   = (tpq_reg == 16'd0) ? 16'd1 : tpq_reg;
    assign ticks_sum = {{(TICKS_W-16){1'b0}}, tick_pos_reg} + {1'b0, elapsed_reg};
    assign prod_next = PROD_W'(next_reg) * PROD_W'(tempo_reg);
    assign divc_next = DIVC_W'(TEMPO_DIV_SCALE) * DIVC_W'(tpq_eff);
    assign rem_sum   = {1'b0, remacc_reg} + {1'b0, div_rem};
    assign delta_next = div_quot[31:0] + {31'd0, rem_sum[32]};

    // Operand selection for the shared divider; dividends sit at the top.
    always_comb
    begin
        unique case (cmd.div_op)
            OP_TICKS:
            begin
                div_dividend = {ticks_sum, {(DIV_DIVIDEND_W-TICKS_W){1'b0}}};
                div_divisor  = {{(DIV_DIVISOR_W-16){1'b0}}, tpq_eff};
                div_steps    = STEPS_TICKS;
            end
            OP_BPB:
            begin
                div_dividend = {num_reg, {QUARTER_SHIFT{1'b0}},
                                {(DIV_DIVIDEND_W-BPB_NUM_W){1'b0}}};
                div_divisor  = {{(DIV_DIVISOR_W-8){1'b0}}, den_reg};
                div_steps    = STEPS_BPB;
            end
            OP_BEAT:
            begin
                div_dividend = {beat_pos_reg, {(DIV_DIVIDEND_W-BEAT_W){1'b0}}};
                div_divisor  = {{(DIV_DIVISOR_W-BPB_NUM_W){1'b0}},
                                div_quot[BPB_NUM_W-1:0]};
                div_steps    = STEPS_BEAT;
            end
            OP_PROD:
            begin
                div_dividend = {prod_reg, {(DIV_DIVIDEND_W-PROD_W){1'b0}}};
                div_divisor  = {{(DIV_DIVISOR_W-DIVC_W){1'b0}}, divc_reg};
                div_steps    = STEPS_PROD;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
                div_steps    = '0;
            end
        endcase
    end

    tss_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg <= TPQ_RESET;
        end
        else if (cfg_wr_en)
        begin
            tpq_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg    <= kind;
            elapsed_reg <= elapsed_ticks;
            next_reg    <= next_ticks;
            tempo_reg   <= tempo_scaled;
            num_reg     <= meter_num;
            den_reg     <= meter_den;
        end
        if (cmd.do_mul)
        begin
            prod_reg <= prod_next;
            divc_reg <= divc_next;
        end
        if (cmd.clear_pos)
        begin
            delta_reg <= '0;
        end
        else if (cmd.capture && (cmd.cap_op == OP_PROD))
        begin
            delta_reg <= delta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remacc_reg   <= '0;
            tick_pos_reg <= '0;
            beat_pos_reg <= '0;
            bar_pos_reg  <= '0;
        end
        else if (cmd.clear_pos)
        begin
            remacc_reg   <= '0;
            tick_pos_reg <= '0;
            beat_pos_reg <= '0;
            bar_pos_reg  <= '0;
        end
        else if (cmd.capture)
        begin
            unique case (cmd.cap_op)
                OP_TICKS:
                begin
                    beat_pos_reg <= beat_pos_reg + div_quot[31:0];
                    tick_pos_reg <= div_rem[15:0];
                end
                OP_BEAT:
                begin
                    bar_pos_reg  <= bar_pos_reg + div_quot[31:0];
                    beat_pos_reg <= div_rem;
                end
                OP_PROD:
                begin
                    remacc_reg <= rem_sum[31:0];
                end
                default:
                begin
                    remacc_reg <= remacc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_delta_reg <= delta_reg;
            bar_count_reg    <= bar_pos_reg;
            beat_count_reg   <= beat_pos_reg;
            tick_in_beat_reg <= tick_pos_reg;
        end
    end

    assign st.restart  = kind_reg;
    assign st.den_zero = (den_reg == 8'd0);
    assign st.bpb_zero = (div_quot[BPB_NUM_W-1:0] == '0);
    assign st.div_done = div_done;
    assign st.div_busy = div_busy;
    assign st.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign sample_delta = sample_delta_reg;
    assign bar_count    = bar_count_reg;
    assign beat_count   = beat_count_reg;
    assign tick_in_beat = tick_in_beat_reg;

endmodule

// ===== hdl/tss_ctrl.sv =====
// ============================================================================
// Tempo sample scheduler controller
// Sequences input capture, the four divisions and the result write.
// ============================================================================
module tss_ctrl
    import tss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.div_op = OP_TICKS;
        cmd.cap_op = OP_TICKS;
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (st.restart)
                begin
                    cmd.clear_pos = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.do_mul    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_op    = OP_TICKS;
                    state_next    = ST_TICK_DIV;
                end
            end
            ST_TICK_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.capture   = 1'b1;
                    cmd.cap_op    = OP_TICKS;
                    cmd.div_start = 1'b1;
                    if (st.den_zero)
                    begin
                        cmd.div_op = OP_PROD;
                        state_next = ST_PROD_DIV;
                    end
                    else
                    begin
                        cmd.div_op = OP_BPB;
                        state_next = ST_BPB_DIV;
                    end
                end
            end
            ST_BPB_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.capture   = 1'b1;
                    cmd.cap_op    = OP_BPB;
                    cmd.div_start = 1'b1;
                    if (st.bpb_zero)
                    begin
                        cmd.div_op = OP_PROD;
                        state_next = ST_PROD_DIV;
                    end
                    else
                    begin
                        cmd.div_op = OP_BEAT;
                        state_next = ST_BEAT_DIV;
                    end
                end
            end
            ST_BEAT_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.capture   = 1'b1;
                    cmd.cap_op    = OP_BEAT;
                    cmd.div_start = 1'b1;
                    cmd.div_op    = OP_PROD;
                    state_next    = ST_PROD_DIV;
                end
            end
            ST_PROD_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.capture = 1'b1;
                    cmd.cap_op  = OP_PROD;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tempo_sample_scheduler_top.sv =====
// Sequence: after acceptance a scheduling step passes the multiply state and the tick, beats-per-bar,
// beat and sample divisions of the shared bit-serial divider before reaching the result register; the
// meter divisions are skipped when their divisor is zero, and a restart goes straight to the result.
// Throughput: one transaction at a time; the next is taken the cycle after the previous result is
// registered, even while it is still stalled.
// Reset: asynchronous active low; clears position, remainder and handshake state, tpq = 96.
// ============================================================================
// Tempo sample scheduler top level
// Converts sequencer steps into musical position and sample counts.
// ============================================================================
`include "tempo_sample_scheduler_top_macros.svh"

module tempo_sample_scheduler_top
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: ticks_per_quarter, written directly.
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [23:0] elapsed_ticks,
    input  logic [23:0] next_ticks,
    input  logic [31:0] tempo_scaled,
    input  logic [7:0]  meter_num,
    input  logic [7:0]  meter_den,

    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_delta,
    output logic [31:0] bar_count,
    output logic [31:0] beat_count,
    output logic [15:0] tick_in_beat
);

    // The controller and datapath talk only through these two structures.
    // Each transaction walks through capture, multiply, tick division,
    // beats-per-bar division, bar folding and the sample division, whose
    // remainder feeds the wrapping accumulator; restarts and zero divisors skip steps.
    cmd_t    cmd;
    status_t st;

    tss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath owns the configuration register, the position state, the
    // shared divider and the output register that decouples the result from
    // the next incoming transaction.
    tss_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .kind          (kind),
        .elapsed_ticks (elapsed_ticks),
        .next_ticks    (next_ticks),
        .tempo_scaled  (tempo_scaled),
        .meter_num     (meter_num),
        .meter_den     (meter_den),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_delta  (sample_delta),
        .bar_count     (bar_count),
        .beat_count    (beat_count),
        .tick_in_beat  (tick_in_beat)
    );

    // An accepted transaction keeps the input stalled in the next cycle.
    `TSS_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, in_valid && !in_stall, in_stall)

    // The divider is never restarted while it is still iterating.
    `TSS_ASSERT_SAME(a_start_when_free, clk, rst_n, cmd.div_start, !st.div_busy)

    // The completion strobe lasts exactly one cycle.
    `TSS_ASSERT_NEXT(a_done_pulse, clk, rst_n, st.div_done, !st.div_done)

    // A result is written only when the output register can take it.
    `TSS_ASSERT_SAME(a_load_when_free, clk, rst_n, cmd.load_out, st.out_free)

endmodule
